>>> rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rau_pkg;

    localparam int OPERAND_W = 16;
    localparam int NUM_W     = 33;
    localparam int DEN_W     = 31;

    // Operands after sign normalization need one extra bit.
    localparam int OP_W   = OPERAND_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int MAG_W  = SUM_W - 1;
    localparam int CNT_W  = $clog2(MAG_W + 1);

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_SUB     = 3'd1;
    localparam logic [2:0] CMD_MUL     = 3'd2;
    localparam logic [2:0] CMD_DIV     = 3'd3;
    localparam logic [2:0] CMD_GREATER = 3'd4;
    localparam logic [2:0] CMD_LESS    = 3'd5;
    localparam logic [2:0] CMD_EQUAL   = 3'd6;
    localparam logic [2:0] CMD_REDUCE  = 3'd7;

    typedef struct packed {
        logic [2:0]                  command;
        logic signed [OPERAND_W-1:0] first_numerator;
        logic signed [OPERAND_W-1:0] first_denominator;
        logic signed [OPERAND_W-1:0] second_numerator;
        logic signed [OPERAND_W-1:0] second_denominator;
    } in_word_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] result_numerator;
        logic [DEN_W-1:0]        result_denominator;
        logic                    compare_true;
        logic                    status;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_GCD,
        ST_DIV,
        ST_FORM,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/rau_cell.sv
`timescale 1ns / 1ps
`default_nettype none

// One bit slice of a shift and subtract divider.
module rau_cell (
    input  wire logic               clk,
    input  wire rau_pkg::div_ctrl_t ctrl,
    input  wire logic               ge,
    input  wire logic               dividend_bit,
    input  wire logic               divisor_bit,
    input  wire logic               rem_in,
    input  wire logic               quo_in,
    input  wire logic               borrow_in,
    output logic                    rem_bit,
    output logic                    quo_bit,
    output logic                    borrow_out
);
    import rau_pkg::*;

    logic rem_reg;
    logic quo_reg;
    logic diff_bit;

    assign diff_bit   = rem_in ^ divisor_bit ^ borrow_in;
    assign borrow_out = (~rem_in & divisor_bit) | (~(rem_in ^ divisor_bit) & borrow_in);

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg <= 1'b0;
            quo_reg <= dividend_bit;
        end
        else if (ctrl.step)
        begin
            rem_reg <= ge ? diff_bit : rem_in;
            quo_reg <= quo_in;
        end
    end

    assign rem_bit = rem_reg;
    assign quo_bit = quo_reg;

endmodule

`default_nettype wire

>>> rtl/rau_div_row.sv
`timescale 1ns / 1ps
`default_nettype none

module rau_div_row #(
    parameter int N = rau_pkg::MAG_W
) (
    input  wire logic               clk,
    input  wire rau_pkg::div_ctrl_t ctrl,
    input  wire logic [N-1:0]       dividend,
    input  wire logic [N-1:0]       divisor,
    output logic [N-1:0]            quotient
);
    import rau_pkg::*;

    logic [N-1:0] rem;
    logic [N-1:0] quo;
    logic [N:0]   borrow;
    logic [N-1:0] rem_in_v;
    logic [N-1:0] quo_in_v;
    logic         ge;

    // The remainder and quotient form one long shift line through the cells.
    assign borrow[0] = 1'b0;
    assign rem_in_v  = {rem[N-2:0], quo[N-1]};
    assign quo_in_v  = {quo[N-2:0], ge};
    assign ge        = rem[N-1] | ~borrow[N];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        rau_cell u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .ge           (ge),
            .dividend_bit (dividend[i]),
            .divisor_bit  (divisor[i]),
            .rem_in       (rem_in_v[i]),
            .quo_in       (quo_in_v[i]),
            .borrow_in    (borrow[i]),
            .rem_bit      (rem[i]),
            .quo_bit      (quo[i]),
            .borrow_out   (borrow[i+1])
        );
    end

    assign quotient = quo;

endmodule

`default_nettype wire

>>> rtl/rau_gcd.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary GCD, one step per cycle.
module rau_gcd #(
    parameter int N = rau_pkg::MAG_W
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [N-1:0] x,
    input  wire logic [N-1:0] y,
    output logic              done,
    output logic [N-1:0]      g
);
    import rau_pkg::*;

    localparam int K_W = $clog2(N + 1);

    logic           busy_reg, busy_next;
    logic [N-1:0]   x_reg, x_next;
    logic [N-1:0]   y_reg, y_next;
    logic [K_W-1:0] k_reg, k_next;

    assign done = busy_reg && ((x_reg == '0) || (y_reg == '0));
    assign g    = N'((x_reg | y_reg) << k_reg);

    always_comb
    begin
        busy_next = busy_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        k_next    = k_reg;
        if (start)
        begin
            busy_next = 1'b1;
            x_next    = x;
            y_next    = y;
            k_next    = '0;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        else if (busy_reg)
        begin
            if (!x_reg[0] && !y_reg[0])
            begin
                x_next = x_reg >> 1;
                y_next = y_reg >> 1;
                k_next = k_reg + K_W'(1);
            end
            else if (!x_reg[0])
            begin
                x_next = x_reg >> 1;
            end
            else if (!y_reg[0])
            begin
                y_next = y_reg >> 1;
            end
            else if (x_reg >= y_reg)
            begin
                x_next = x_reg - y_reg;
            end
            else
            begin
                y_next = y_reg - x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        k_reg <= k_next;
    end

endmodule

`default_nettype wire

>>> rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// An input error skips to the result; a comparison passes through the multiply states;
// a fraction result through them (a reduce skips them), the sum, binary GCD and the divider.
// One word is in work at a time; throughput is set by the GCD loop and the divider cell row.
// The result register lets a new word be taken while a finished result is still stalled.
// Reset (rst_n, asynchronous, active low) clears the sequencer and the result valid flag.
module rational_arithmetic_unit (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_stall,
    input  wire rau_pkg::in_word_t  cmd_word,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output rau_pkg::out_word_t      res_word
);
    import rau_pkg::*;

    state_t                    state_reg, state_next;
    logic [2:0]                cmd_reg, cmd_next;
    logic signed [OP_W-1:0]    a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic signed [PROD_W-1:0]  m1_reg, m1_next, m2_reg, m2_next, m3_reg, m3_next;
    logic                      neg_reg, neg_next;
    logic [MAG_W-1:0]          nm_reg, nm_next, dm_reg, dm_next, g_reg, g_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    out_word_t                 pend_reg, pend_next, out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;

    logic signed [OP_W-1:0]    mx, my;
    logic signed [PROD_W-1:0]  prod;
    logic signed [SUM_W-1:0]   sum;
    logic [SUM_W-1:0]          sum_abs;
    logic [PROD_W-1:0]         den_abs;
    logic signed [OP_W-1:0]    in_a, in_b, in_c, in_d;
    logic                      gcd_start, gcd_done;
    logic [MAG_W-1:0]          gcd_g;
    div_ctrl_t                 div_ctrl;
    logic [MAG_W-1:0]          qn, qd;
    logic signed [MAG_W:0]     sq;
    out_word_t                 err_word;

    assign prod      = mx * my;
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = out_valid_reg;
    assign res_word  = out_reg;

    assign err_word = '{result_numerator: '0, result_denominator: '0,
                        compare_true: 1'b0, status: 1'b1};

    always_comb
    begin
        in_a = OP_W'(cmd_word.first_numerator);
        in_b = OP_W'(cmd_word.first_denominator);
        in_c = OP_W'(cmd_word.second_numerator);
        in_d = OP_W'(cmd_word.second_denominator);
        // Move each denominator sign into its numerator; the reduced value is unchanged.
        if (cmd_word.first_denominator < 0)
        begin
            in_a = -in_a;
            in_b = -in_b;
        end
        if (cmd_word.second_denominator < 0)
        begin
            in_c = -in_c;
            in_d = -in_d;
        end
    end

    always_comb
    begin
        case (cmd_reg)
            CMD_ADD: sum = SUM_W'(m1_reg) + SUM_W'(m2_reg);
            CMD_SUB: sum = SUM_W'(m1_reg) - SUM_W'(m2_reg);
            default: sum = SUM_W'(m1_reg);
        endcase
        sum_abs = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
        den_abs = m3_reg[PROD_W-1] ? PROD_W'(-m3_reg) : PROD_W'(m3_reg);
        sq = neg_reg ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        m1_next        = m1_reg;
        m2_next        = m2_reg;
        m3_next        = m3_reg;
        neg_next       = neg_reg;
        nm_next        = nm_reg;
        dm_next        = dm_reg;
        g_next         = g_reg;
        cnt_next       = cnt_reg;
        pend_next      = pend_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && res_stall;
        mx             = a_reg;
        my             = d_reg;
        gcd_start      = 1'b0;
        div_ctrl       = '{load: 1'b0, step: 1'b0};

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd_word.command;
                    a_next   = in_a;
                    b_next   = in_b;
                    c_next   = in_c;
                    d_next   = in_d;
                    m1_next  = PROD_W'(in_a);
                    m3_next  = PROD_W'(in_b);
                    if ((cmd_word.first_denominator == '0) ||
                        ((cmd_word.command != CMD_REDUCE) &&
                         (cmd_word.second_denominator == '0)))
                    begin
                        pend_next  = err_word;
                        state_next = ST_DONE;
                    end
                    else if (cmd_word.command == CMD_REDUCE)
                    begin
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        state_next = ST_MUL1;
                    end
                end
            end
            ST_MUL1:
            begin
                mx      = a_reg;
                my      = (cmd_reg == CMD_MUL) ? c_reg : d_reg;
                m1_next = prod;
                if ((cmd_reg == CMD_MUL) || (cmd_reg == CMD_DIV))
                    state_next = ST_MUL3;
                else
                    state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                mx      = c_reg;
                my      = b_reg;
                m2_next = prod;
                if ((cmd_reg == CMD_GREATER) || (cmd_reg == CMD_LESS) ||
                    (cmd_reg == CMD_EQUAL))
                begin
                    pend_next = '0;
                    case (cmd_reg)
                        CMD_GREATER: pend_next.compare_true = (prod < m1_reg);
                        CMD_LESS:    pend_next.compare_true = (m1_reg < prod);
                        default:     pend_next.compare_true = (m1_reg == prod);
                    endcase
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL3;
                end
            end
            ST_MUL3:
            begin
                mx         = b_reg;
                my         = (cmd_reg == CMD_DIV) ? c_reg : d_reg;
                m3_next    = prod;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (m3_reg == '0)
                begin
                    pend_next  = err_word;
                    state_next = ST_DONE;
                end
                else
                begin
                    neg_next   = sum[SUM_W-1] ^ m3_reg[PROD_W-1];
                    nm_next    = MAG_W'(sum_abs);
                    dm_next    = MAG_W'(den_abs);
                    gcd_start  = 1'b1;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (gcd_done)
                begin
                    g_next        = gcd_g;
                    div_ctrl.load = 1'b1;
                    cnt_next      = '0;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                div_ctrl.step = 1'b1;
                cnt_next      = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MAG_W - 1))
                    state_next = ST_FORM;
            end
            ST_FORM:
            begin
                pend_next = '0;
                if (qn == '0)
                begin
                    pend_next.result_denominator = DEN_W'(1);
                end
                else
                begin
                    pend_next.result_numerator   = NUM_W'(sq);
                    pend_next.result_denominator = DEN_W'(qd);
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !res_stall)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    rau_gcd #(.N(MAG_W)) u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gcd_start),
        .x     (nm_next),
        .y     (dm_next),
        .done  (gcd_done),
        .g     (gcd_g)
    );

    rau_div_row #(.N(MAG_W)) u_row_num (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (nm_reg),
        .divisor  (g_reg),
        .quotient (qn)
    );

    rau_div_row #(.N(MAG_W)) u_row_den (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (dm_reg),
        .divisor  (g_reg),
        .quotient (qd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        m1_reg   <= m1_next;
        m2_reg   <= m2_next;
        m3_reg   <= m3_next;
        neg_reg  <= neg_next;
        nm_reg   <= nm_next;
        dm_reg   <= dm_next;
        g_reg    <= g_next;
        cnt_reg  <= cnt_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("input taken but sequencer did not leave idle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.status |->
            (res_word.result_numerator == '0) && (res_word.result_denominator == '0) &&
            !res_word.compare_true)
        else $error("error word carries nonzero fields");

    a_compare_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_word.compare_true |->
            (res_word.result_denominator == '0) && !res_word.status)
        else $error("comparison word carries a fraction");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (cnt_reg < CNT_W'(MAG_W)))
        else $error("divider step count overran");

endmodule

`default_nettype wire
